// ----- design/lbcs_pkg.sv -----
// Package: shared types, register indexes and helpers for the LED blink-code sequencer.
package lbcs_pkg;

    // Per-channel phase of the blink sequence
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LIT   = 2'd1,
        PH_DARK  = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 8;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ON_TICKS       = 3'd0,
        REG_OFF_TICKS      = 3'd1,
        REG_PAUSE_TICKS    = 3'd2,
        REG_CHANNEL_ENABLE = 3'd3,
        REG_INCREASE_CODE  = 3'd4,
        REG_DECREASE_CODE  = 3'd5
    } cfg_index_t;

    // Field widths
    localparam int TICK_WIDTH   = 8;
    localparam int ENABLE_WIDTH = 3;
    localparam int CODE_WIDTH   = 5;
    localparam int CMD_WIDTH    = 8;
    localparam int LED_WIDTH    = 3;
    localparam int MAX_CHANNELS = 8;

    // Channel selector value that addresses all channels
    localparam logic [1:0] SEL_ALL = 2'b11;

    // Operation kinds carried in tuser
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Register reset values
    localparam logic [TICK_WIDTH-1:0]   ON_TICKS_RST    = 8'd2;
    localparam logic [TICK_WIDTH-1:0]   OFF_TICKS_RST   = 8'd2;
    localparam logic [TICK_WIDTH-1:0]   PAUSE_TICKS_RST = 8'd6;
    localparam logic [ENABLE_WIDTH-1:0] ENABLE_RST      = 3'd7;
    localparam logic [CODE_WIDTH-1:0]   INCREASE_RST    = 5'd30;
    localparam logic [CODE_WIDTH-1:0]   DECREASE_RST    = 5'd31;

    // Timer load for a phase of the given length: a phase lasts max(len,1) ticks
    function automatic logic [TICK_WIDTH-1:0] phase_load(input logic [TICK_WIDTH-1:0] len);
        return (len == '0) ? '0 : len - 1'b1;
    endfunction

endpackage

// ----- design/led_blink_code_sequencer.sv -----
// LED blink-code sequencer: command decode, per-channel phase sequencing and output staging.
// The LED levels for an item go to the output register, or to the skid entry while the output stalls.
// Throughput: one item per cycle while s_tready is high; the channel state updates in the transfer cycle, so each
// item sees everything earlier items left behind.
// Output: an output register plus one skid entry; input tready drops only while both are full.
// Reset: aresetn is synchronous, active low; registers return to defaults, all channels idle.
module led_blink_code_sequencer
    import lbcs_pkg::*;
#(
    parameter int NUM_CHANNELS = 3,
    parameter int COUNT_WIDTH  = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,

    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] command
    input  logic [0:0]                s_tuser,   // [0] operation (0 command, 1 tick)

    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata    // [2:0] led_levels, [7:3] zero
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TICK_WIDTH-1:0]   on_ticks_reg;
    logic [TICK_WIDTH-1:0]   off_ticks_reg;
    logic [TICK_WIDTH-1:0]   pause_ticks_reg;
    logic [ENABLE_WIDTH-1:0] channel_enable_reg;
    logic [CODE_WIDTH-1:0]   increase_code_reg;
    logic [CODE_WIDTH-1:0]   decrease_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_ticks_reg       <= ON_TICKS_RST;
            off_ticks_reg      <= OFF_TICKS_RST;
            pause_ticks_reg    <= PAUSE_TICKS_RST;
            channel_enable_reg <= ENABLE_RST;
            increase_code_reg  <= INCREASE_RST;
            decrease_code_reg  <= DECREASE_RST;
        end else if (cfg_wr_en) begin
            // indexes past the list fall into default and are dropped
            unique case (cfg_index)
                REG_ON_TICKS:       on_ticks_reg       <= cfg_wdata;
                REG_OFF_TICKS:      off_ticks_reg      <= cfg_wdata;
                REG_PAUSE_TICKS:    pause_ticks_reg    <= cfg_wdata;
                REG_CHANNEL_ENABLE: channel_enable_reg <= cfg_wdata[ENABLE_WIDTH-1:0];
                REG_INCREASE_CODE:  increase_code_reg  <= cfg_wdata[CODE_WIDTH-1:0];
                REG_DECREASE_CODE:  decrease_code_reg  <= cfg_wdata[CODE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_xfer;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] flash_count_reg   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] flash_count_next  [NUM_CHANNELS];
    phase_t                 phase_reg         [NUM_CHANNELS];
    phase_t                 phase_next        [NUM_CHANNELS];
    logic [TICK_WIDTH-1:0]  phase_timer_reg   [NUM_CHANNELS];
    logic [TICK_WIDTH-1:0]  phase_timer_next  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] flashes_done_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] flashes_done_next [NUM_CHANNELS];

    // Only the first ENABLE_WIDTH channels have an enable bit; the rest stay disabled
    logic [MAX_CHANNELS-1:0] enable_ext;
    logic [NUM_CHANNELS-1:0] chan_en;
    logic [NUM_CHANNELS-1:0] lit_vec;
    logic [MAX_CHANNELS-1:0] lit_ext;
    logic [LED_WIDTH-1:0]    levels_next;

    logic [1:0]             cmd_sel;
    logic [CODE_WIDTH-1:0]  cmd_val;
    logic                   is_tick;

    assign enable_ext = MAX_CHANNELS'(channel_enable_reg);
    assign cmd_sel    = s_tdata[7:6];
    assign cmd_val    = s_tdata[CODE_WIDTH-1:0];
    assign is_tick    = (s_tuser[0] == OP_TICK);

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_en[c]           = enable_ext[c];
            flash_count_next[c]  = flash_count_reg[c];
            phase_next[c]        = phase_reg[c];
            phase_timer_next[c]  = phase_timer_reg[c];
            flashes_done_next[c] = flashes_done_reg[c];

            if (in_xfer && is_tick) begin
                if (!chan_en[c]) begin
                    // disabled: parked idle, count kept
                    phase_next[c]        = PH_IDLE;
                    phase_timer_next[c]  = '0;
                    flashes_done_next[c] = '0;
                end else if (phase_reg[c] != PH_IDLE && phase_timer_reg[c] != '0) begin
                    phase_timer_next[c] = phase_timer_reg[c] - 1'b1;
                end else begin
                    unique case (phase_reg[c])
                        PH_LIT: begin
                            if (flashes_done_reg[c] < COUNT_MAX)
                                flashes_done_next[c] = flashes_done_reg[c] + 1'b1;
                            phase_next[c]       = PH_DARK;
                            phase_timer_next[c] = phase_load(off_ticks_reg);
                        end
                        PH_DARK: begin
                            // count may have changed mid-group; checked here
                            if (flashes_done_reg[c] < flash_count_reg[c]) begin
                                phase_next[c]       = PH_LIT;
                                phase_timer_next[c] = phase_load(on_ticks_reg);
                            end else begin
                                phase_next[c]       = PH_PAUSE;
                                phase_timer_next[c] = phase_load(pause_ticks_reg);
                            end
                        end
                        PH_IDLE, PH_PAUSE: begin
                            flashes_done_next[c] = '0;
                            if (flash_count_reg[c] != '0) begin
                                phase_next[c]       = PH_LIT;
                                phase_timer_next[c] = phase_load(on_ticks_reg);
                            end else begin
                                phase_next[c]       = PH_IDLE;
                                phase_timer_next[c] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (in_xfer && chan_en[c]) begin
                // command byte
                if (cmd_sel == SEL_ALL) begin
                    flash_count_next[c] = '0;
                end else if (int'(cmd_sel) == c) begin
                    // increase wins when both codes match
                    if (cmd_val == increase_code_reg) begin
                        if (flash_count_reg[c] < COUNT_MAX)
                            flash_count_next[c] = flash_count_reg[c] + 1'b1;
                    end else if (cmd_val == decrease_code_reg) begin
                        if (flash_count_reg[c] != '0)
                            flash_count_next[c] = flash_count_reg[c] - 1'b1;
                    end else begin
                        flash_count_next[c] = COUNT_WIDTH'(cmd_val);
                    end
                end
            end

            lit_vec[c] = chan_en[c] && (phase_next[c] == PH_LIT);
        end
        lit_ext     = MAX_CHANNELS'(lit_vec);
        levels_next = lit_ext[LED_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                flash_count_reg[c]  <= '0;
                phase_reg[c]        <= PH_IDLE;
                phase_timer_reg[c]  <= '0;
                flashes_done_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                flash_count_reg[c]  <= flash_count_next[c];
                phase_reg[c]        <= phase_next[c];
                phase_timer_reg[c]  <= phase_timer_next[c];
                flashes_done_reg[c] <= flashes_done_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic [LED_WIDTH-1:0] out_data_reg;
    logic [LED_WIDTH-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            // output slot free this cycle: drain skid first, else take new result
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_xfer;
            end
        end else if (in_xfer) begin
            // output stalled: park the new result
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_xfer)
                out_data_reg <= levels_next;
        end
        if (out_valid_reg && !m_tready && in_xfer)
            skid_data_reg <= levels_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_data_reg);

`ifndef SYNTHESIS
    // skid entry is only ever occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // every input transfer leaves a result pending
    a_result_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_tvalid)
        else $error("input transfer produced no pending result");

    // a tick on channel 0 while it is disabled parks it idle
    a_disabled_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && is_tick && !chan_en[0]) |=> (phase_reg[0] == PH_IDLE))
        else $error("disabled channel not parked idle");

    // channel 0 never carries a running timer while idle
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg[0] == PH_IDLE) |-> (phase_timer_reg[0] == '0))
        else $error("idle channel with nonzero phase timer");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the LED blink-code sequencer: random command and tick streams checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lbcs_pkg::*;

    localparam int NCH = 3;
    localparam logic [7:0] COUNT_TOP = 8'hff;
    // Index past the last register, the block must ignore writes to it
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd6;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int HOLD_OFF_CYCLES = 400;

    // One input transfer: operation in tuser, command byte in tdata
    typedef struct packed {
        logic                 op;
        logic [CMD_WIDTH-1:0] cmd;
    } blink_item_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;    // [7:0] command
    logic [0:0]                s_tuser   = '0;    // [0] operation
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [7:0]                m_tdata;           // [2:0] led_levels

    led_blink_code_sequencer #(
        .NUM_CHANNELS(NCH),
        .COUNT_WIDTH (8)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: register shadow and per-channel sequencer state
    // ------------------------------------------------------------------
    logic [TICK_WIDTH-1:0]   cfg_on_len, cfg_off_len, cfg_pause_len;
    logic [ENABLE_WIDTH-1:0] cfg_enable;
    logic [CODE_WIDTH-1:0]   cfg_up_code, cfg_down_code;

    logic [7:0] flash_total   [NCH];
    phase_t     phase_now     [NCH];
    logic [7:0] ticks_left    [NCH];
    logic [7:0] flashes_shown [NCH];

    blink_item_t           pending_items[$];
    logic [LED_WIDTH-1:0]  expected_leds[$];

    blink_item_t offer_item;
    logic        offer_live = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_left = 0;
    int          mismatches = 0;
    logic [7:0]  want_leds;

    // A phase of length len lasts max(len,1) ticks; the timer holds ticks after this one
    task automatic start_phase(input int c, input phase_t ph, input logic [7:0] len);
        phase_now[c] = ph;
        ticks_left[c] = (len == 8'd0) ? 8'd0 : len - 8'd1;
    endtask

    task automatic tick_channel(input int c);
        if (!cfg_enable[c]) begin
            // disabled: parked idle, count kept
            phase_now[c] = PH_IDLE;
            ticks_left[c] = '0;
            flashes_shown[c] = '0;
        end else if (phase_now[c] != PH_IDLE && ticks_left[c] != 8'd0) begin
            ticks_left[c] = ticks_left[c] - 8'd1;
        end else begin
            case (phase_now[c])
                PH_LIT: begin
                    if (flashes_shown[c] != COUNT_TOP)
                        flashes_shown[c] = flashes_shown[c] + 8'd1;
                    start_phase(c, PH_DARK, cfg_off_len);
                end
                PH_DARK: begin
                    // count is rechecked here, so a change mid-group lands at a dark end
                    if (flashes_shown[c] < flash_total[c])
                        start_phase(c, PH_LIT, cfg_on_len);
                    else
                        start_phase(c, PH_PAUSE, cfg_pause_len);
                end
                default: begin
                    flashes_shown[c] = '0;
                    if (flash_total[c] != 8'd0) begin
                        start_phase(c, PH_LIT, cfg_on_len);
                    end else begin
                        phase_now[c] = PH_IDLE;
                        ticks_left[c] = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic predict_leds(input blink_item_t it, output logic [LED_WIDTH-1:0] leds);
        logic [1:0] sel;
        logic [4:0] val;
        sel = it.cmd[7:6];
        val = it.cmd[4:0];
        if (it.op == OP_TICK) begin
            for (int c = 0; c < NCH; c++) tick_channel(c);
        end else if (sel == SEL_ALL) begin
            for (int c = 0; c < NCH; c++)
                if (cfg_enable[c]) flash_total[c] = '0;
        end else if (cfg_enable[sel]) begin
            // increase wins when both codes are equal
            if (val == cfg_up_code) begin
                if (flash_total[sel] != COUNT_TOP) flash_total[sel] = flash_total[sel] + 8'd1;
            end else if (val == cfg_down_code) begin
                if (flash_total[sel] != 8'd0) flash_total[sel] = flash_total[sel] - 8'd1;
            end else begin
                flash_total[sel] = {3'b000, val};
            end
        end
        leds = '0;
        for (int c = 0; c < NCH; c++)
            leds[c] = cfg_enable[c] && (phase_now[c] == PH_LIT);
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers at the falling edge, holds until the transfer
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!offer_live) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offer_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= offer_item.cmd;
                s_tuser <= offer_item.op;
                offer_live = 1'b1;
            end else begin
                // idle cycle: junk on the data lines
                s_tvalid <= 1'b0;
                s_tdata <= 8'($urandom_range(0, 255));
                s_tuser <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Input transfer: predict the LED levels it must produce
    always @(posedge aclk) begin
        logic [LED_WIDTH-1:0] leds;
        if (aresetn && s_tvalid && s_tready) begin
            predict_leds(offer_item, leds);
            expected_leds.push_back(leds);
            offer_live = 1'b0;
        end
    end

    // Result receiver: random back-pressure plus a counted long hold-off
    always @(negedge aclk) begin
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: each transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_leds.size() == 0) begin
                mismatches++;
                $display("%0t: led transfer with nothing expected, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want_leds = {5'b00000, expected_leds.pop_front()};
                if (m_tdata !== want_leds) begin
                    mismatches++;
                    $display("%0t: led levels expected %h, actual %h", $time, want_leds, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [1:0] sel, input logic b5, input logic [4:0] val);
        blink_item_t it;
        it.op = OP_COMMAND;
        it.cmd = {sel, b5, val};
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        blink_item_t it;
        for (int i = 0; i < n; i++) begin
            it.op = OP_TICK;
            it.cmd = 8'($urandom_range(0, 255));    // ignored on a tick
            pending_items.push_back(it);
        end
    endtask

    // Mix of ticks and commands; codes are drawn often so counts move up and down
    task automatic push_random(input int n);
        blink_item_t it;
        logic [1:0]  sel;
        logic [4:0]  val;
        int          pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55) begin
                it.op = OP_TICK;
                it.cmd = 8'($urandom_range(0, 255));
                pending_items.push_back(it);
            end else begin
                sel = ($urandom_range(0, 9) == 0) ? SEL_ALL : 2'($urandom_range(0, 2));
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    val = cfg_up_code;
                else if (pick < 5)
                    val = cfg_down_code;
                else
                    val = 5'($urandom_range(0, 31));
                push_cmd(sel, 1'($urandom_range(0, 1)), val);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ON_TICKS:       cfg_on_len = val;
            REG_OFF_TICKS:      cfg_off_len = val;
            REG_PAUSE_TICKS:    cfg_pause_len = val;
            REG_CHANNEL_ENABLE: cfg_enable = val[ENABLE_WIDTH-1:0];
            REG_INCREASE_CODE:  cfg_up_code = val[CODE_WIDTH-1:0];
            REG_DECREASE_CODE:  cfg_down_code = val[CODE_WIDTH-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_IDX_WIDTH'($urandom_range(0, 7));
        cfg_wdata <= CFG_DATA_WIDTH'($urandom_range(0, 255));
    endtask

    // Narrow registers get junk in their unused upper bits
    task automatic set_regs(input logic [7:0] on_len, input logic [7:0] off_len,
                            input logic [7:0] pause_len, input logic [2:0] en,
                            input logic [4:0] up, input logic [4:0] down);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        write_reg(REG_ON_TICKS, on_len);
        write_reg(REG_OFF_TICKS, off_len);
        write_reg(REG_PAUSE_TICKS, pause_len);
        write_reg(REG_CHANNEL_ENABLE, {junk[7:3], en});
        write_reg(REG_INCREASE_CODE, {junk[2:0], up});
        write_reg(REG_DECREASE_CODE, {junk[5:3], down});
    endtask

    // Sender pauses until every queued item has gone in and every result came back
    task automatic wait_idle();
        while (pending_items.size() != 0 || offer_live || expected_leds.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_on_len = ON_TICKS_RST;
        cfg_off_len = OFF_TICKS_RST;
        cfg_pause_len = PAUSE_TICKS_RST;
        cfg_enable = ENABLE_RST;
        cfg_up_code = INCREASE_RST;
        cfg_down_code = DECREASE_RST;
        for (int c = 0; c < NCH; c++) begin
            flash_total[c] = '0;
            phase_now[c] = PH_IDLE;
            ticks_left[c] = '0;
            flashes_shown[c] = '0;
        end

        // first segment: slow sender, heavily stalled receiver
        send_idle_pct = 29;
        recv_idle_pct = 82;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        push_ticks(1);                              // tick with every channel idle
        push_cmd(2'd0, 1'b0, 5'd1);                 // set ch0 to one flash
        push_cmd(2'd1, 1'b1, 5'd29);                // set ch1, bit 5 ignored
        push_cmd(2'd2, 1'b0, DECREASE_RST);         // decrease at zero stays zero
        push_cmd(2'd2, 1'b0, INCREASE_RST);
        push_cmd(2'd2, 1'b1, INCREASE_RST);
        push_ticks(6);                              // idle channels start on this tick
        push_cmd(2'd1, 1'b0, 5'd0);                 // drop count to zero mid-group
        push_ticks(6);
        push_cmd(SEL_ALL, 1'b1, 5'd31);             // clear all
        push_cmd(2'd0, 1'b0, 5'd3);
        push_cmd(SEL_ALL, 1'b0, 5'd0);
        push_ticks(3);
        wait_idle();

        // zero-length phases, increase code zero
        set_regs(8'd0, 8'd0, 8'd0, 3'd7, 5'd0, 5'd31);
        push_random(180);
        wait_idle();

        // ch1 disabled; write to a missing register; long receiver hold-off
        set_regs(8'd3, 8'd1, 8'd4, 3'd5, 5'd30, 5'd31);
        write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 40; i++) push_cmd(2'd2, 1'($urandom_range(0, 1)), cfg_up_code);
        push_random(160);
        @(posedge aclk);
        hold_off_left = HOLD_OFF_CYCLES;
        wait_idle();

        // equal codes: increase wins
        set_regs(8'd1, 8'd2, 8'd3, 3'd7, 5'd12, 5'd12);
        push_random(180);
        wait_idle();

        // second segment: roles swapped
        send_idle_pct = 82;
        recv_idle_pct = 29;

        // longest phases; run ch0 into the top count and back down
        set_regs(8'd255, 8'd255, 8'd255, 3'd7, 5'd31, 5'd0);
        push_cmd(2'd0, 1'b0, 5'd17);
        for (int i = 0; i < 262; i++) push_cmd(2'd0, 1'($urandom_range(0, 1)), cfg_up_code);
        for (int i = 0; i < 20; i++) push_cmd(2'd0, 1'($urandom_range(0, 1)), cfg_down_code);
        push_random(120);
        wait_idle();

        // everything disabled
        set_regs(8'd2, 8'd0, 8'd1, 3'd0, 5'd30, 5'd31);
        push_random(150);
        wait_idle();

        set_regs(8'd1, 8'd1, 8'd2, 3'd3, 5'd7, 5'd21);
        push_random(180);
        wait_idle();

        // last segment: no idling on either side, random settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 4; k++) begin
            set_regs(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            push_random(180);
            wait_idle();
        end

        // spare edges catch stray results
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
